[rtl/sfwc_pkg.sv]
// Shared constants, register indexes and payload types of the stereo fuzz waveshaper.
package sfwc_pkg;

    localparam int SAMPLE_BITS        = 24;
    localparam int NUM_CHANNELS_DEF   = 2;
    localparam int STAGES_PER_CHANNEL = 9;
    localparam int FRAC_SHIFT         = 32 - SAMPLE_BITS;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_LOWPASS  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGHPASS = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPONENT = 2'd2;

    localparam logic [15:0] LOWPASS_COEF_RST  = 16'd14861;
    localparam logic [15:0] HIGHPASS_COEF_RST = 16'd238;
    localparam logic [6:0]  EXPONENT_RST      = 7'd1;

    // 2^x fraction polynomial and ceil(2^32 / 100) for the divide by 100
    localparam logic signed [33:0] EXP_A      = 34'sd43025;
    localparam logic signed [33:0] EXP_B      = 34'sd22511;
    localparam logic signed [33:0] DIV_RECIP  = 34'sd42949673;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
    } out_t;

endpackage

[rtl/stereo_fuzz_waveshaper_chain.sv]
// Stereo fuzz waveshaper: lowpass chain, power-law shaper, DC blocker, lowpass chain.
// A frame with a zero sample skips the chain and goes straight to the finish step.
// Otherwise each channel runs its nine one-pole stages and a channel close; the shaper passes a
// zero input through, else it normalizes the magnitude and runs the log2 squaring rounds,
// all on one shared 34x34 multiplier; the finish step waits for a free output register.
// One frame at a time; reset clears all filter state and loads the register defaults.
module stereo_fuzz_waveshaper_chain #(
    parameter int NUM_CHANNELS = sfwc_pkg::NUM_CHANNELS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  sfwc_pkg::in_t                      in_data,
    output logic                               out_valid,
    input  logic                               out_ready,
    output sfwc_pkg::out_t                     out_data,
    input  logic                               cfg_wr_en,
    input  logic [sfwc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [sfwc_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import sfwc_pkg::*;

    localparam int DEPTH  = NUM_CHANNELS * STAGES_PER_CHANNEL;
    localparam int ADDR_W = $clog2(DEPTH);

    // Sequencer codes
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LP_MUL  = 4'd1;
    localparam logic [3:0] S_LP_ACC  = 4'd2;
    localparam logic [3:0] S_SH_INIT = 4'd3;
    localparam logic [3:0] S_SH_NORM = 4'd4;
    localparam logic [3:0] S_SH_SQ   = 4'd5;
    localparam logic [3:0] S_SH_SQA  = 4'd6;
    localparam logic [3:0] S_SH_LOG  = 4'd7;
    localparam logic [3:0] S_SH_DIV  = 4'd8;
    localparam logic [3:0] S_SH_CORR = 4'd9;
    localparam logic [3:0] S_SH_EXA  = 4'd10;
    localparam logic [3:0] S_SH_EXB  = 4'd11;
    localparam logic [3:0] S_SH_MAG  = 4'd12;
    localparam logic [3:0] S_CH_END  = 4'd13;
    localparam logic [3:0] S_FIN     = 4'd14;

    localparam logic [3:0] STG_TRACK = 4'd4;   // DC tracker stage
    localparam logic [3:0] STG_LAST  = 4'd8;

    // Configuration registers
    logic [15:0] lp_coef_reg;
    logic [15:0] hp_coef_reg;
    logic [6:0]  exp_reg;

    // Sequencer and datapath registers
    logic [3:0]                    state_reg;
    logic                          ch_reg;
    logic [3:0]                    stage_reg;
    logic signed [31:0]            x_reg;
    logic signed [SAMPLE_BITS-1:0] rin_reg;
    logic [31:0]                   mant_reg;
    logic [4:0]                    k_reg;
    logic [15:0]                   frac_reg;
    logic [3:0]                    rnd_reg;
    logic signed [29:0]            dvd_reg;
    logic [15:0]                   f_reg;
    logic signed [7:0]             nexp_reg;
    logic signed [67:0]            prod_reg;
    logic signed [SAMPLE_BITS-1:0] res_reg [2];
    logic signed [31:0]            st_reg [DEPTH];
    logic                          out_valid_reg;
    out_t                          out_data_reg;

    logic in_fire;
    logic gate_zero;
    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign gate_zero = (in_data.left_in == '0) || (in_data.right_in == '0);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Filter state entry of the current channel and stage
    logic [ADDR_W-1:0] addr;
    logic signed [31:0] z;
    assign addr = ADDR_W'(int'(ch_reg) * STAGES_PER_CHANNEL + int'(stage_reg));
    assign z    = st_reg[addr];

    logic [15:0] coef;
    assign coef = (stage_reg == STG_TRACK) ? hp_coef_reg : lp_coef_reg;

    // Shared multiplier operand select
    logic signed [32:0] diff;
    logic signed [22:0] lg;
    logic [16:0]        inner;
    logic signed [33:0] mul_a;
    logic signed [33:0] mul_b;
    logic signed [67:0] mul_p;

    assign diff  = {x_reg[31], x_reg} - {z[31], z};
    assign lg    = {7'($signed({2'b00, k_reg}) - 7'sd30), frac_reg};
    assign inner = 17'(EXP_A) + {1'b0, prod_reg[31:16]};

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_LP_MUL:
            begin
                mul_a = {diff[32], diff};
                mul_b = {18'b0, coef};
            end
            S_SH_SQ:
            begin
                mul_a = {2'b00, mant_reg};
                mul_b = {2'b00, mant_reg};
            end
            S_SH_LOG:
            begin
                mul_a = 34'(lg);
                mul_b = {27'b0, exp_reg};
            end
            S_SH_DIV:
            begin
                mul_a = 34'($signed(prod_reg[29:0]));
                mul_b = DIV_RECIP;
            end
            S_SH_EXA:
            begin
                mul_a = {18'b0, f_reg};
                mul_b = EXP_B;
            end
            S_SH_EXB:
            begin
                mul_a = {18'b0, f_reg};
                mul_b = {17'b0, inner};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // One-pole update: z + floor(diff*c / 2^16), saturated to 32 bits
    logic signed [34:0] acc;
    logic signed [31:0] znew;
    assign acc  = 35'(z) + 35'($signed(prod_reg[49:16]));
    assign znew = (acc > 35'sd2147483647)  ? 32'sh7FFFFFFF :
                  (acc < -35'sd2147483648) ? 32'sh80000000 : acc[31:0];

    // DC blocker output: x minus tracked low part, saturated
    logic signed [32:0] hp_diff;
    logic signed [31:0] hp_out;
    assign hp_diff = {x_reg[31], x_reg} - {znew[31], znew};
    assign hp_out  = (hp_diff > 33'sd2147483647)  ? 32'sh7FFFFFFF :
                     (hp_diff < -33'sd2147483648) ? 32'sh80000000 : hp_diff[31:0];

    // Log2 squaring round
    logic [32:0] sq;
    assign sq = prod_reg[63:31];

    // Floor divide by 100: reciprocal estimate, then one correction step
    logic signed [23:0] q0;
    logic signed [30:0] rem;
    logic signed [23:0] e_div;
    logic signed [24:0] t_exp;
    assign q0    = prod_reg[55:32];
    assign rem   = 31'(dvd_reg) - ((31'(q0) <<< 6) + (31'(q0) <<< 5) + (31'(q0) <<< 2));
    assign e_div = q0 + ((rem >= 31'sd100) ? 24'sd1 : 24'sd0);
    assign t_exp = 25'(e_div) + 25'sd1835008;

    // Magnitude from 2^n mantissa, saturated to 31 bits
    logic [16:0]        mm;
    logic signed [7:0]  up_sh;
    logic signed [7:0]  dn_sh;
    logic [48:0]        wide;
    logic [30:0]        mag;
    logic signed [31:0] shaped;
    assign mm    = 17'h10000 + {1'b0, prod_reg[31:16]};
    assign up_sh = nexp_reg - 8'sd16;
    assign dn_sh = 8'sd16 - nexp_reg;
    assign wide  = {32'b0, mm} << up_sh[4:0];

    always_comb
    begin
        if (nexp_reg >= 8'sd16)
        begin
            if (up_sh > 8'sd31 || wide > 49'h7FFFFFFF)
                mag = 31'h7FFFFFFF;
            else
                mag = wide[30:0];
        end
        else if (dn_sh >= 8'sd17)
        begin
            mag = '0;
        end
        else
        begin
            mag = 31'(mm >> dn_sh[4:0]);
        end
    end

    assign shaped = x_reg[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

    // Output rounding: round half up by FRAC_SHIFT bits, saturate to sample width
    localparam int RW = 33 - FRAC_SHIFT;
    logic signed [32:0]             rnd_sum;
    logic signed [RW-1:0]           rnd_v;
    logic signed [SAMPLE_BITS-1:0]  res_sat;
    localparam logic signed [RW-1:0] SMP_MAX = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RW-1:0] SMP_MIN = RW'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    assign rnd_sum = {x_reg[31], x_reg} + (33'sd1 <<< (FRAC_SHIFT - 1));
    assign rnd_v   = rnd_sum[32:FRAC_SHIFT];
    assign res_sat = (rnd_v > SMP_MAX) ? SMP_MAX[SAMPLE_BITS-1:0] :
                     (rnd_v < SMP_MIN) ? SMP_MIN[SAMPLE_BITS-1:0] : rnd_v[SAMPLE_BITS-1:0];

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_coef_reg <= LOWPASS_COEF_RST;
            hp_coef_reg <= HIGHPASS_COEF_RST;
            exp_reg     <= EXPONENT_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_LOWPASS:  lp_coef_reg <= cfg_data[15:0];
                CFG_HIGHPASS: hp_coef_reg <= cfg_data[15:0];
                CFG_EXPONENT: exp_reg     <= cfg_data[6:0];
                default:      ;
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ch_reg        <= 1'b0;
            stage_reg     <= '0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < DEPTH; i++)
                st_reg[i] <= '0;
        end
        else
        begin
            // The finish step reloads the output register itself
            if (out_valid_reg && out_ready && state_reg != S_FIN)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        // Drop both channels to zero when either raw sample is zero
                        res_reg[0] <= '0;
                        res_reg[1] <= '0;
                        x_reg      <= {in_data.left_in, FRAC_SHIFT'(0)};
                        rin_reg    <= in_data.right_in;
                        ch_reg     <= 1'b0;
                        stage_reg  <= '0;
                        state_reg  <= gate_zero ? S_FIN : S_LP_MUL;
                    end
                end
                S_LP_MUL:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_LP_ACC;
                end
                S_LP_ACC:
                begin
                    st_reg[addr] <= znew;
                    x_reg        <= (stage_reg == STG_TRACK) ? hp_out : znew;
                    stage_reg    <= stage_reg + 4'd1;
                    if (stage_reg == STG_LAST)
                        state_reg <= S_CH_END;
                    else if (stage_reg == STG_TRACK - 4'd1)
                        state_reg <= S_SH_INIT;
                    else
                        state_reg <= S_LP_MUL;
                end
                S_SH_INIT:
                begin
                    mant_reg  <= x_reg[31] ? 32'(-{x_reg[31], x_reg}) : x_reg;
                    k_reg     <= 5'd31;
                    frac_reg  <= '0;
                    rnd_reg   <= '0;
                    state_reg <= (x_reg == '0) ? S_LP_MUL : S_SH_NORM;
                end
                S_SH_NORM:
                begin
                    if (mant_reg[31])
                        state_reg <= S_SH_SQ;
                    else
                    begin
                        mant_reg <= mant_reg << 1;
                        k_reg    <= k_reg - 5'd1;
                    end
                end
                S_SH_SQ:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_SH_SQA;
                end
                S_SH_SQA:
                begin
                    frac_reg  <= {frac_reg[14:0], sq[32]};
                    mant_reg  <= sq[32] ? sq[32:1] : sq[31:0];
                    rnd_reg   <= rnd_reg + 4'd1;
                    state_reg <= (rnd_reg == 4'd15) ? S_SH_LOG : S_SH_SQ;
                end
                S_SH_LOG:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_SH_DIV;
                end
                S_SH_DIV:
                begin
                    dvd_reg   <= prod_reg[29:0];
                    prod_reg  <= mul_p;
                    state_reg <= S_SH_CORR;
                end
                S_SH_CORR:
                begin
                    nexp_reg  <= t_exp[23:16];
                    f_reg     <= t_exp[15:0];
                    state_reg <= S_SH_EXA;
                end
                S_SH_EXA:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_SH_EXB;
                end
                S_SH_EXB:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= S_SH_MAG;
                end
                S_SH_MAG:
                begin
                    x_reg     <= shaped;
                    state_reg <= S_LP_MUL;
                end
                S_CH_END:
                begin
                    res_reg[ch_reg] <= res_sat;
                    if (int'(ch_reg) < NUM_CHANNELS - 1)
                    begin
                        ch_reg    <= 1'b1;
                        stage_reg <= '0;
                        x_reg     <= {rin_reg, FRAC_SHIFT'(0)};
                        state_reg <= S_LP_MUL;
                    end
                    else
                        state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    // Hold the frame until the output register is free
                    if (!out_valid_reg || out_ready)
                    begin
                        out_data_reg.left_out  <= res_reg[0];
                        out_data_reg.right_out <= res_reg[1];
                        out_valid_reg          <= 1'b1;
                        state_reg              <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    // A gated frame skips all processing
    a_gate_skips: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && gate_zero |=> state_reg == S_FIN)
        else $error("zero-gated frame entered the filter chain");

    // New results only come out of the finish step
    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result presented outside the finish step");

    // Stage counter stays inside the chain while filtering
    a_stage_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LP_MUL |-> stage_reg <= STG_LAST)
        else $error("stage index beyond the chain");

    // Shaper starts a log2 pass from a normalized mantissa
    a_norm_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SH_SQ && rnd_reg == 4'd0 |-> mant_reg[31])
        else $error("log2 pass started on an unnormalized mantissa");

endmodule

[tb/tb_stereo_fuzz_waveshaper_chain.sv]
// Self-checking testbench for the stereo fuzz waveshaper chain: directed and random traffic, bit-exact predictor.
`timescale 1ns / 1ps

module tb_stereo_fuzz_waveshaper_chain;
    import sfwc_pkg::*;

    localparam int  CYCLE_LIMIT  = 3000000;
    localparam int  RANDOM_ITEMS = 700;
    localparam int  NUM_PHASES   = 6;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    in_t                    in_data;
    logic                   out_valid;
    logic                   out_ready;
    out_t                   out_data;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    stereo_fuzz_waveshaper_chain dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Requests waiting to be offered, and frames the block still owes us
    in_t  pending_frames[$];
    out_t expected_frames[$];
    int   errors;
    int   cycles;
    logic hold_req;

    // Predictor copy of the block's registers and filter memory
    logic [15:0] lp_coef;
    logic [15:0] hp_coef;
    logic [6:0]  exp_h;
    int          chan_state[2][STAGES_PER_CHANNEL];

    // Clock: 8 ns period
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    function automatic longint sat_to(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    // One-pole smoother: z moves toward x by the Q0.16 fraction c, floor rounding
    function automatic longint pole_update(inout int z, input longint x, input logic [15:0] c);
        longint v;
        v = longint'(z) + (((x - longint'(z)) * longint'(c)) >>> 16);
        z = int'(sat_to(v, 32));
        return longint'(z);
    endfunction

    function automatic longint floor_by_100(longint n);
        if (n >= 0)
            return n / 100;
        return -((-n + 99) / 100);
    endfunction

    // Power-law shaper built from the log2 / exp2 approximation
    function automatic longint power_shape(longint x);
        logic [63:0] m;
        logic [63:0] mant;
        logic [63:0] mag;
        int          k;
        longint      frac;
        longint      lg;
        longint      t;
        longint      n;
        longint      f;
        longint      inner;
        longint      mm;
        longint      s;
        if (x == 0)
            return 0;
        m = (x < 0) ? -x : x;
        k = 0;
        frac = 0;
        for (int i = 0; i < 32; i++)
            if (m[i])
                k = i;
        mant = m << (31 - k);
        // log2 fraction by repeated squaring, one bit per round
        for (int i = 0; i < 16; i++)
        begin
            mant = (mant * mant) >> 31;
            frac = frac <<< 1;
            if (mant >= 64'h1_0000_0000)
            begin
                frac = frac | 1;
                mant = mant >> 1;
            end
        end
        lg = (longint'(k) - 30) * 65536 + frac;
        t = floor_by_100(lg * longint'(exp_h)) + 28 * 65536;
        n = t >>> 16;
        f = t - n * 65536;
        inner = longint'(EXP_A) + ((longint'(EXP_B) * f) >>> 16);
        mm = 65536 + ((f * inner) >>> 16);
        if (n >= 16)
            mag = (n - 16 > 31) ? 64'h7FFF_FFFF : (64'(mm) << (n - 16));
        else
        begin
            s = 16 - n;
            mag = (s >= 63) ? 64'd0 : (64'(mm) >> s);
        end
        if (mag > 64'h7FFF_FFFF)
            mag = 64'h7FFF_FFFF;
        return (x < 0) ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] shape_channel(int ch, longint sample);
        longint v;
        longint dc;
        v = sample <<< FRAC_SHIFT;
        for (int s = 0; s < 4; s++)
            v = pole_update(chan_state[ch][s], v, lp_coef);
        v = power_shape(v);
        dc = pole_update(chan_state[ch][4], v, hp_coef);
        v = sat_to(v - dc, 32);
        for (int s = 5; s < 9; s++)
            v = pole_update(chan_state[ch][s], v, lp_coef);
        v = (v + (longint'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
        return SAMPLE_BITS'(sat_to(v, SAMPLE_BITS));
    endfunction

    // Either raw sample zero: silent frame, filter memory untouched
    function automatic out_t predict_frame(in_t req);
        out_t res;
        res = '0;
        if (req.left_in != 0 && req.right_in != 0)
        begin
            res.left_out = shape_channel(0, longint'(req.left_in));
            res.right_out = shape_channel(1, longint'(req.right_in));
        end
        return res;
    endfunction

    // Driver: bursts of requests with random gaps; predict at each accepted request
    int burst_left;
    int gap_left;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left = 1;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && in_ready)
                expected_frames.push_back(predict_frame(in_data));
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pending_frames.size() > 0)
                begin
                    in_data  <= pending_frames.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        // Roughly a third of bursts run back to back with no gap
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 250);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern switches mode now and then; honor a long hold-off on request
    int stall_mode;
    int mode_left;
    int hold_cnt;
    bit hold_taken;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_mode = 0;
            mode_left  = 0;
            hold_cnt   = 0;
            hold_taken = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_frames.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, out_data);
                end
                else
                begin
                    if (out_data.left_out !== expected_frames[0].left_out)
                    begin
                        errors++;
                        $display("%0t: left_out expected %h actual %h", $time,
                                 expected_frames[0].left_out, out_data.left_out);
                    end
                    if (out_data.right_out !== expected_frames[0].right_out)
                    begin
                        errors++;
                        $display("%0t: right_out expected %h actual %h", $time,
                                 expected_frames[0].right_out, out_data.right_out);
                    end
                    void'(expected_frames.pop_front());
                end
            end
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1;
                hold_cnt   = 1500;
            end
            if (mode_left <= 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(20, 400);
            end
            mode_left--;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_ready <= 1'b0;
            end
            else
                case (stall_mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 0);
                    2: out_ready <= ($urandom_range(0, 7) == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Write one register and mirror it in the predictor
    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            CFG_LOWPASS:  lp_coef = val;
            CFG_HIGHPASS: hp_coef = val;
            CFG_EXPONENT: exp_h = val[6:0];
            default: ;
        endcase
    endtask

    // Hold until nothing is queued, offered or owed, then let the block settle
    task automatic drain();
        do
            @(posedge clk);
        while (pending_frames.size() != 0 || in_valid || expected_frames.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 13)
            return SAMPLE_BITS'($urandom);
        else if (pick < 16)
            return SAMPLE_BITS'(int'($urandom_range(0, 511)) - 256);
        else if (pick < 17)
            return '0;
        else if (pick < 18)
            return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        else if (pick < 19)
            return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        return SAMPLE_BITS'(int'($urandom_range(1, 8)) *
                            (($urandom_range(0, 1) == 0) ? 1 : -1));
    endfunction

    task automatic push_frame(logic signed [SAMPLE_BITS-1:0] l, logic signed [SAMPLE_BITS-1:0] r);
        in_t req;
        req.left_in  = l;
        req.right_in = r;
        pending_frames.push_back(req);
    endtask

    localparam logic signed [SAMPLE_BITS-1:0] SMAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SMIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    initial
    begin
        errors    = 0;
        cycles    = 0;
        hold_req  = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        lp_coef   = LOWPASS_COEF_RST;
        hp_coef   = HIGHPASS_COEF_RST;
        exp_h     = EXPONENT_RST;
        foreach (chan_state[c, s])
            chan_state[c][s] = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed frames under reset defaults: extremes, zero gate on each side, tiny values
        push_frame(SMAX, SMAX);
        push_frame(SMIN, SMIN);
        push_frame(SMAX, SMIN);
        push_frame(SMIN, SMAX);
        push_frame('0, 24'sd5);
        push_frame(24'sd5, '0);
        push_frame('0, '0);
        push_frame(24'sd1, 24'sd1);
        push_frame(-24'sd1, -24'sd1);
        push_frame(24'sd1, -24'sd1);
        push_frame(SMAX, 24'sd1);
        push_frame(SMIN, -24'sd1);
        push_frame(24'h555555, 24'h2AAAAA);
        push_frame(24'hAAAAAA, 24'h555555);
        drain();

        // Phases sweep the registers: defaults, extremes, exponent 0 and above 100,
        // zero lowpass (lowpass states frozen), an out-of-range index, then random settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                1:
                begin
                    write_reg(CFG_LOWPASS, 16'hFFFF);
                    write_reg(CFG_HIGHPASS, 16'd0);
                    write_reg(CFG_EXPONENT, 16'd100);
                end
                2:
                begin
                    write_reg(CFG_LOWPASS, 16'd0);
                    write_reg(CFG_HIGHPASS, 16'hFFFF);
                    write_reg(CFG_EXPONENT, 16'd0);
                end
                3:
                begin
                    write_reg(CFG_LOWPASS, 16'd40000);
                    write_reg(CFG_HIGHPASS, 16'd1000);
                    write_reg(CFG_EXPONENT, 16'd127);
                    write_reg(2'd3, 16'h1234);
                end
                4, 5:
                begin
                    write_reg(CFG_LOWPASS, CFG_DATA_W'($urandom));
                    write_reg(CFG_HIGHPASS, CFG_DATA_W'($urandom));
                    write_reg(CFG_EXPONENT, CFG_DATA_W'($urandom_range(1, 100)));
                end
                default: ;
            endcase
            for (int i = 0; i < RANDOM_ITEMS / NUM_PHASES; i++)
                push_frame(rand_sample(), rand_sample());
            // Long receiver hold-off while the sender keeps offering
            if (ph == 1)
                hold_req <= 1'b1;
            drain();
        end

        repeat (50) @(posedge clk);
        if (errors == 0 && expected_frames.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
